@@ rtl/core/two_button_debounce_long_press_macros.svh @@
// ----------------------------------------------------------------------------
// Two-button debounce assertion macros
// Shared assertion shorthands for the debounce block checkers
// ----------------------------------------------------------------------------
`ifndef TWO_BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define TWO_BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH

// clocked property, ignored while reset is high
`define TBDLP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked property, checked in reset as well
`define TBDLP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/tbdlp_pkg.sv @@
// ----------------------------------------------------------------------------
// Two-button debounce package
// Word types, register indexes and reset values for the debounce block
// ----------------------------------------------------------------------------
package tbdlp_pkg;

  localparam int TIME_WIDTH_DEF  = 32;
  localparam int NOW_WIDTH       = 32;
  localparam int CFG_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 1;

  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1000;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_TIME   = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS_TIME = 1'd1;

  typedef struct packed {
    logic [NOW_WIDTH-1:0] now_ms;
    logic                 s1_raw;
    logic                 s2_raw;
  } tbdlp_poll_t;

  typedef struct packed {
    logic s1_down;
    logic s2_down;
    logic both_down;
    logic s1_press;
    logic s2_press;
    logic s1_long;
  } tbdlp_result_t;

  typedef struct packed {
    logic stable;
    logic press;
  } tbdlp_btn_t;

endpackage

@@ rtl/core/tbdlp_settle.sv @@
// ----------------------------------------------------------------------------
// Button settle unit
// Debounce state of one button: raw level tracking, hold timer, stable level
// ----------------------------------------------------------------------------
module tbdlp_settle import tbdlp_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  raw,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic [CFG_WIDTH-1:0]  debounce_time,
  output tbdlp_btn_t            btn
);

  logic                  stable;
  logic                  last_raw;
  logic [TIME_WIDTH-1:0] change_time;
  logic                  stable_next;
  logic                  last_raw_next;
  logic [TIME_WIDTH-1:0] change_time_next;
  logic [TIME_WIDTH-1:0] held;
  logic                  press;

  assign held = now - change_time;

  always_comb begin
    stable_next      = stable;
    last_raw_next    = last_raw;
    change_time_next = change_time;
    press            = 1'b0;
    if (raw != last_raw) begin
      last_raw_next    = raw;
      change_time_next = now;
    end else if (held >= TIME_WIDTH'(debounce_time) && stable != raw) begin
      stable_next = raw;
      press       = raw;
    end
  end

  assign btn.stable = stable_next;
  assign btn.press  = press;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable      <= 1'b0;
      last_raw    <= 1'b0;
      change_time <= '0;
    end else if (en) begin
      stable      <= stable_next;
      last_raw    <= last_raw_next;
      change_time <= change_time_next;
    end
  end

endmodule

@@ rtl/core/tbdlp_long_press.sv @@
// ----------------------------------------------------------------------------
// Long-press unit
// Tracks the start of a button one hold and fires one long-press pulse
// ----------------------------------------------------------------------------
module tbdlp_long_press import tbdlp_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  tbdlp_btn_t            btn,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic [CFG_WIDTH-1:0]  long_press_time,
  output logic                  long_pulse
);

  logic                  was_down;
  logic [TIME_WIDTH-1:0] press_time;
  logic                  long_done;
  logic [TIME_WIDTH-1:0] press_time_next;
  logic                  long_done_next;
  logic                  done_eff;
  logic                  new_press;
  logic [TIME_WIDTH-1:0] held;

  assign new_press       = btn.stable && !was_down;
  assign press_time_next = new_press ? now : press_time;
  assign done_eff        = new_press ? 1'b0 : long_done;
  assign held            = now - press_time_next;
  assign long_pulse      = btn.stable && !done_eff && (held >= TIME_WIDTH'(long_press_time));
  assign long_done_next  = done_eff || long_pulse;

  always_ff @(posedge clk) begin
    if (rst) begin
      was_down   <= 1'b0;
      press_time <= '0;
      long_done  <= 1'b0;
    end else if (en) begin
      was_down   <= btn.stable;
      press_time <= press_time_next;
      long_done  <= long_done_next;
    end
  end

endmodule

@@ rtl/core/two_button_debounce_long_press.sv @@
// ----------------------------------------------------------------------------
// Two-button debounce with long press
// Poll-driven debouncer for two buttons, long-press detect on button one
// ----------------------------------------------------------------------------
// usage:
//   poll channel (poll_valid / poll_stall / poll): one word per poll with a
//   millisecond timestamp and the raw levels of both buttons
//   result channel (result_valid / result_stall / result): one word per poll
//   with debounced levels and one-shot press and long-press pulses
//   cfg port: cfg_wen writes cfg_data into the register at cfg_index
//   (debounce time, long-press time); write only while the block is idle
// latency: 2 cycles from poll accept to result valid (input register, then
//   result register); throughput one poll per cycle, set by the single
//   combinational update of the button state between the two registers
// reset: button state and timers clear, registers return to 20 ms and
//   1000 ms, both channels empty
// stall: a stalled result holds; the input register still takes one more
//   poll, then poll_stall rises until the result is taken
// ----------------------------------------------------------------------------
module two_button_debounce_long_press import tbdlp_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       poll_valid,
  output logic                       poll_stall,
  input  tbdlp_poll_t                poll,
  output logic                       result_valid,
  input  logic                       result_stall,
  output tbdlp_result_t              result,
  input  logic                       cfg_wen,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data
);

  logic                  poll_q_valid;
  tbdlp_poll_t           poll_q;
  logic                  advance;
  logic                  take;
  logic                  step;
  logic [TIME_WIDTH-1:0] now;
  logic [CFG_WIDTH-1:0]  debounce_time;
  logic [CFG_WIDTH-1:0]  long_press_time;
  tbdlp_btn_t            btn1;
  tbdlp_btn_t            btn2;
  logic                  long_pulse;
  tbdlp_result_t         result_next;

  assign advance    = !result_valid || !result_stall;
  assign poll_stall = poll_q_valid && !advance;
  assign take       = poll_valid && !poll_stall;
  assign step       = poll_q_valid && advance;
  assign now        = TIME_WIDTH'(poll_q.now_ms);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time   <= DEBOUNCE_RESET;
      long_press_time <= LONG_PRESS_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TIME:   debounce_time   <= cfg_data;
        REG_LONG_PRESS_TIME: long_press_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_q_valid <= 1'b0;
    end else if (take) begin
      poll_q_valid <= 1'b1;
    end else if (advance) begin
      poll_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      poll_q <= poll;
    end
  end

  tbdlp_settle #(.TIME_WIDTH(TIME_WIDTH)) u_settle1 (
    .clk           (clk),
    .rst           (rst),
    .en            (step),
    .raw           (poll_q.s1_raw),
    .now           (now),
    .debounce_time (debounce_time),
    .btn           (btn1)
  );

  tbdlp_settle #(.TIME_WIDTH(TIME_WIDTH)) u_settle2 (
    .clk           (clk),
    .rst           (rst),
    .en            (step),
    .raw           (poll_q.s2_raw),
    .now           (now),
    .debounce_time (debounce_time),
    .btn           (btn2)
  );

  tbdlp_long_press #(.TIME_WIDTH(TIME_WIDTH)) u_long (
    .clk             (clk),
    .rst             (rst),
    .en              (step),
    .btn             (btn1),
    .now             (now),
    .long_press_time (long_press_time),
    .long_pulse      (long_pulse)
  );

  always_comb begin
    result_next.s1_down   = btn1.stable;
    result_next.s2_down   = btn2.stable;
    result_next.both_down = btn1.stable && btn2.stable;
    result_next.s1_press  = btn1.press;
    result_next.s2_press  = btn2.press;
    result_next.s1_long   = long_pulse;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= poll_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_next;
    end
  end

endmodule

@@ rtl/core/tbdlp_checker.sv @@
// ----------------------------------------------------------------------------
// Two-button debounce checker
// Port-level assertions on the poll and result words of the debounce block
// ----------------------------------------------------------------------------
`include "two_button_debounce_long_press_macros.svh"

module tbdlp_checker import tbdlp_pkg::*; (
  input logic          clk,
  input logic          rst,
  input logic          poll_valid,
  input logic          poll_stall,
  input tbdlp_poll_t   poll,
  input logic          result_valid,
  input logic          result_stall,
  input tbdlp_result_t result
);

  // both-down flag agrees with the two debounced levels
  `TBDLP_ASSERT(a_both_down, clk, rst,
    result_valid |-> (result.both_down == (result.s1_down && result.s2_down)),
    "both_down mismatch")

  // press and long-press pulses come with the button down
  `TBDLP_ASSERT(a_pulse_down, clk, rst,
    result_valid |-> (((!result.s1_press && !result.s1_long) || result.s1_down) &&
                      (!result.s2_press || result.s2_down)),
    "pulse while released")

  // no result word right after reset
  `TBDLP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid, "result valid after reset")

  // stalled result word holds
  `TBDLP_ASSERT(a_result_hold, clk, rst,
    (result_valid && result_stall) |=> (result_valid && $stable(result)),
    "stalled result changed")

  // stalled poll word holds
  `TBDLP_ASSERT(a_poll_hold, clk, rst,
    (poll_valid && poll_stall) |=> (poll_valid && $stable(poll)),
    "stalled poll changed")

endmodule

bind two_button_debounce_long_press tbdlp_checker u_tbdlp_checker (.*);

@@ tb/tb_two_button_debounce_long_press.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-button debounce with long press testbench
// Streams timestamped polls through the block under random idling and
// stalls, predicts every result word and compares it field by field
// ----------------------------------------------------------------------------
module tb_two_button_debounce_long_press;
  import tbdlp_pkg::*;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       poll_valid = 1'b0;
  logic                       poll_stall;
  tbdlp_poll_t                poll = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  tbdlp_result_t              result;
  logic                       cfg_wen = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_DEBOUNCE_TIME;
  logic [CFG_WIDTH-1:0]       cfg_data = '0;

  two_button_debounce_long_press DUT (
    .clk          (clk),
    .rst          (rst),
    .poll_valid   (poll_valid),
    .poll_stall   (poll_stall),
    .poll         (poll),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // predicted button state
  logic [CFG_WIDTH-1:0] pred_debounce = DEBOUNCE_RESET;
  logic [CFG_WIDTH-1:0] long_ms = LONG_PRESS_RESET;
  logic [1:0]           btn_stable = '0;
  logic [1:0]           btn_last_raw = '0;
  logic [NOW_WIDTH-1:0] btn_since [2] = '{default: '0};
  logic                 s1_held = 1'b0;
  logic                 s1_long_sent = 1'b0;
  logic [NOW_WIDTH-1:0] s1_down_at = '0;

  tbdlp_poll_t   poll_q [$];
  tbdlp_result_t expected_q [$];
  tbdlp_result_t want;

  logic [NOW_WIDTH-1:0] gen_now = '0;
  int unsigned polls_queued = 0;
  int unsigned polls_sent = 0;
  int unsigned words_checked = 0;
  int unsigned press_seen = 0;
  int unsigned long_seen = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 10;
  int unsigned recv_idle_pct = 85;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned hold_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic tbdlp_result_t debounce_poll(tbdlp_poll_t p);
    tbdlp_result_t r;
    logic [1:0] raw;
    logic [1:0] press;
    raw = {p.s2_raw, p.s1_raw};
    press = '0;
    r = '0;
    for (int b = 0; b < 2; b++) begin
      if (raw[b] != btn_last_raw[b]) begin
        btn_last_raw[b] = raw[b];
        btn_since[b] = p.now_ms;
      end else if (p.now_ms - btn_since[b] >= pred_debounce && btn_stable[b] != raw[b]) begin
        btn_stable[b] = raw[b];
        press[b] = raw[b];
      end
    end
    if (btn_stable[0] && !s1_held) begin
      s1_down_at = p.now_ms;
      s1_long_sent = 1'b0;
    end
    if (btn_stable[0] && !s1_long_sent && p.now_ms - s1_down_at >= long_ms) begin
      s1_long_sent = 1'b1;
      r.s1_long = 1'b1;
    end
    s1_held = btn_stable[0];
    r.s1_down = btn_stable[0];
    r.s2_down = btn_stable[1];
    r.both_down = btn_stable[0] & btn_stable[1];
    r.s1_press = press[0];
    r.s2_press = press[1];
    return r;
  endfunction

  function automatic void check_field(string name, logic exp_bit, logic got_bit);
    if (got_bit !== exp_bit) begin
      $display("%0t: %s expected %0b actual %0b", $time, name, exp_bit, got_bit);
      mismatches++;
    end
  endfunction

  task automatic push_poll(input logic [NOW_WIDTH-1:0] t, input logic s1, input logic s2);
    tbdlp_poll_t p;
    p.now_ms = t;
    p.s1_raw = s1;
    p.s2_raw = s2;
    gen_now = t;
    poll_q.push_back(p);
    polls_queued++;
  endtask

  // one press or release with contact bounce, now and then plain noise
  task automatic queue_gesture(input int unsigned dbnc, input int unsigned lng);
    logic [1:0]           target;
    logic [NOW_WIDTH-1:0] step;
    int unsigned          coarse;
    coarse = lng / 3 + 2;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) begin
        step = ($urandom_range(0, 3) == 0) ? $urandom : gen_now + $urandom_range(0, dbnc + 2);
        push_poll(step, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end else begin
      target = {poll_q.size() != 0 ? poll_q[$].s2_raw : 1'b0,
                poll_q.size() != 0 ? poll_q[$].s1_raw : 1'b0} ^ 2'($urandom_range(1, 3));
      repeat ($urandom_range(0, 4)) begin
        push_poll(gen_now + $urandom_range(0, dbnc / 2 + 1), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 4))
          0: step = dbnc - 1 + $urandom_range(0, 2);
          1: step = $urandom_range(0, dbnc / 2 + 2);
          2: step = $urandom_range(0, coarse);
          3: step = lng - 1 + $urandom_range(0, 2);
          default: step = $urandom_range(0, 1);
        endcase
        push_poll(gen_now + step, target[0], target[1]);
      end
    end
  endtask

  task automatic wait_drained();
    while (poll_q.size() != 0 || poll_valid || expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_timing(input int unsigned dbnc, input int unsigned lng);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= REG_DEBOUNCE_TIME;
    cfg_data <= CFG_WIDTH'(dbnc);
    pred_debounce = CFG_WIDTH'(dbnc);
    @(posedge clk);
    cfg_index <= REG_LONG_PRESS_TIME;
    cfg_data <= CFG_WIDTH'(lng);
    long_ms = CFG_WIDTH'(lng);
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else begin
      if (poll_valid && !poll_stall) begin
        expected_q.push_back(debounce_poll(poll));
        polls_sent++;
      end
      if (!poll_valid || !poll_stall) begin
        if (poll_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          poll <= poll_q.pop_front();
          poll_valid <= 1'b1;
        end else begin
          poll_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (holds_done != holds_asked) begin
      hold_left <= 400;
      holds_done <= holds_done + 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %b", $time, result);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        check_field("s1_down", want.s1_down, result.s1_down);
        check_field("s2_down", want.s2_down, result.s2_down);
        check_field("both_down", want.both_down, result.both_down);
        check_field("s1_press", want.s1_press, result.s1_press);
        check_field("s2_press", want.s2_press, result.s2_press);
        check_field("s1_long", want.s1_long, result.s1_long);
        words_checked++;
        press_seen += want.s1_press + want.s2_press;
        long_seen += want.s1_long;
      end
    end
  end

  initial begin : stimulus
    int unsigned d;
    int unsigned l;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset timing: 20 ms debounce, 1000 ms long press
    push_poll(0, 1'b0, 1'b0);
    push_poll(5, 1'b1, 1'b1);
    push_poll(24, 1'b1, 1'b1);
    push_poll(25, 1'b1, 1'b1);
    push_poll(1024, 1'b1, 1'b1);
    push_poll(1025, 1'b1, 1'b1);
    push_poll(70000, 1'b1, 1'b1);
    push_poll(70001, 1'b0, 1'b1);
    push_poll(70020, 1'b0, 1'b1);
    push_poll(70021, 1'b0, 1'b1);
    push_poll(70030, 1'b1, 1'b1);
    push_poll(70050, 1'b1, 1'b1);
    push_poll(71050, 1'b1, 1'b1);
    push_poll(32'hFFFF_FFF0, 1'b0, 1'b0);
    push_poll(32'h0000_0004, 1'b0, 1'b0);
    push_poll(32'hFFFF_FFFF, 1'b1, 1'b0);
    push_poll(32'h0000_0013, 1'b1, 1'b0);
    push_poll(32'h8000_0000, 1'b1, 1'b0);
    push_poll(32'h8000_0001, 1'b0, 1'b0);

    // zero debounce and zero long press
    set_timing(0, 0);
    push_poll(100, 1'b0, 1'b0);
    push_poll(100, 1'b1, 1'b1);
    push_poll(100, 1'b1, 1'b1);
    push_poll(101, 1'b0, 1'b1);
    push_poll(101, 1'b0, 1'b1);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin d = 1; l = 8; end
        1: begin d = 16'hFFFF; l = 16'hFFFF; end
        2: begin d = $urandom_range(1, 40); l = $urandom_range(40, 600); end
        3: begin d = $urandom_range(1, 30); l = 0; end
        4: begin d = 0; l = 16'hFFFF; end
        default: begin d = $urandom_range(0, 16'hFFFF); l = $urandom_range(0, 16'hFFFF); end
      endcase
      set_timing(d, l);
      send_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 85 : 0;
      recv_idle_pct = (ph < 2) ? 85 : (ph < 4) ? 10 : 0;
      if (ph == 1) gen_now = 32'hFFF0_0000;
      while (polls_queued < 25 + 150 * (ph + 1)) queue_gesture(d, l);
      if (ph >= 4) holds_asked++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    $display("checked %0d result words for %0d polls across eight timing settings",
             words_checked, polls_sent);
    $display("saw %0d press and %0d long-press pulses, %0d mismatches",
             press_seen, long_seen, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d words outstanding", expected_q.size() + poll_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
